// ===== rtl/core/sbsm_pkg.sv =====
// Package: shared types, constants and window functions for the serial bank switch mapper.
package sbsm_pkg;

    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned OFFSET_W    = 17;
    localparam int unsigned PRG_BANK_W  = 4;
    localparam int unsigned CHR_BANK_W  = 5;
    localparam int unsigned LOAD_W      = 5;
    localparam int unsigned LOG2_W      = 3;
    localparam int unsigned PADDR_W     = 3;

    localparam logic [LOAD_W-1:0]     LOAD_MARKER   = 5'h10;
    localparam logic [LOAD_W-1:0]     PRG_MODE_BITS = 5'h0C;
    localparam logic [PRG_BANK_W-1:0] PRG_LAST_BANK = 4'hF;
    localparam logic [LOG2_W-1:0]     PRG_LOG2_CAP  = 3'd4;
    localparam logic [LOG2_W-1:0]     CHR_LOG2_CAP  = 3'd5;
    localparam logic [LOG2_W-1:0]     PRG_LOG2_RST  = 3'd4;
    localparam logic [LOG2_W-1:0]     CHR_LOG2_RST  = 3'd5;

    typedef enum logic [1:0] {
        REGION_CHR  = 2'd0,
        REGION_PRG  = 2'd1,
        REGION_WRAM = 2'd2,
        REGION_NONE = 2'd3
    } region_t;

    typedef enum logic [1:0] {
        SEL_CONTROL = 2'd0,
        SEL_CHR_LOW = 2'd1,
        SEL_CHR_HIGH = 2'd2,
        SEL_PRG     = 2'd3
    } reg_sel_t;

    typedef enum logic [0:0] {
        CFG_PRG_LOG2 = 1'b0,
        CFG_CHR_LOG2 = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [PRG_BANK_W-1:0] prg_win0;
        logic [PRG_BANK_W-1:0] prg_win1;
        logic [CHR_BANK_W-1:0] chr_win0;
        logic [CHR_BANK_W-1:0] chr_win1;
    } windows_t;

    typedef struct packed {
        region_t             region;
        logic [OFFSET_W-1:0] mem_offset;
        logic                mem_write;
    } access_t;

    function automatic windows_t calc_windows(
        input logic [LOAD_W-1:0]     ctrl,
        input logic [PRG_BANK_W-1:0] prg_sel,
        input logic [CHR_BANK_W-1:0] chr_low,
        input logic [CHR_BANK_W-1:0] chr_high
    );
        windows_t w;
        case (ctrl[3:2])
            2'd2: begin
                w.prg_win0 = '0;
                w.prg_win1 = prg_sel;
            end
            2'd3: begin
                w.prg_win0 = prg_sel;
                w.prg_win1 = PRG_LAST_BANK;
            end
            default: begin
                w.prg_win0 = {prg_sel[PRG_BANK_W-1:1], 1'b0};
                w.prg_win1 = {prg_sel[PRG_BANK_W-1:1], 1'b1};
            end
        endcase
        if (ctrl[4]) begin
            w.chr_win0 = chr_low;
            w.chr_win1 = chr_high;
        end else begin
            w.chr_win0 = {chr_low[CHR_BANK_W-1:1], 1'b0};
            w.chr_win1 = {chr_low[CHR_BANK_W-1:1], 1'b1};
        end
        return w;
    endfunction

    function automatic logic [PRG_BANK_W-1:0] prg_mask(input logic [LOG2_W-1:0] l);
        logic [PRG_BANK_W:0] one_hot;
        one_hot = '0;
        if (l >= PRG_LOG2_CAP) begin
            return '1;
        end
        one_hot[l[1:0]] = 1'b1;
        return PRG_BANK_W'(one_hot - 1'b1);
    endfunction

    function automatic logic [CHR_BANK_W-1:0] chr_mask(input logic [LOG2_W-1:0] l);
        logic [CHR_BANK_W:0] one_hot;
        one_hot = '0;
        if (l >= CHR_LOG2_CAP) begin
            return '1;
        end
        one_hot[l] = 1'b1;
        return CHR_BANK_W'(one_hot - 1'b1);
    endfunction

endpackage

// ===== rtl/core/sbsm_loader.sv =====
// Serial load register, mapper registers and bank window registers.
module sbsm_loader (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [1:0]                        wr_sel,
    input  logic                              wr_reset_bit,
    input  logic                              wr_data_bit,
    output sbsm_pkg::windows_t                windows,
    output logic [1:0]                        mirror_next
);

    logic [sbsm_pkg::LOAD_W-1:0]     load_shift_reg, load_shift_next;
    logic [sbsm_pkg::LOAD_W-1:0]     control_reg, control_next;
    logic [sbsm_pkg::CHR_BANK_W-1:0] chr_low_reg, chr_low_next;
    logic [sbsm_pkg::CHR_BANK_W-1:0] chr_high_reg, chr_high_next;
    logic [sbsm_pkg::PRG_BANK_W-1:0] prg_sel_reg, prg_sel_next;
    sbsm_pkg::windows_t              windows_reg, windows_next;
    logic [sbsm_pkg::LOAD_W-1:0]     shifted;
    logic                            update;

    always_comb begin
        load_shift_next = load_shift_reg;
        control_next    = control_reg;
        chr_low_next    = chr_low_reg;
        chr_high_next   = chr_high_reg;
        prg_sel_next    = prg_sel_reg;
        update          = 1'b0;
        shifted         = {wr_data_bit, load_shift_reg[sbsm_pkg::LOAD_W-1:1]};
        if (wr_en) begin
            if (wr_reset_bit) begin
                load_shift_next = sbsm_pkg::LOAD_MARKER;
                control_next    = control_reg | sbsm_pkg::PRG_MODE_BITS;
                update          = 1'b1;
            end else if (load_shift_reg[0]) begin
                load_shift_next = sbsm_pkg::LOAD_MARKER;
                update          = 1'b1;
                case (sbsm_pkg::reg_sel_t'(wr_sel))
                    sbsm_pkg::SEL_CONTROL:  control_next  = shifted;
                    sbsm_pkg::SEL_CHR_LOW:  chr_low_next  = shifted;
                    sbsm_pkg::SEL_CHR_HIGH: chr_high_next = shifted;
                    sbsm_pkg::SEL_PRG:      prg_sel_next  = shifted[sbsm_pkg::PRG_BANK_W-1:0];
                    default:                prg_sel_next  = prg_sel_reg;
                endcase
            end else begin
                load_shift_next = shifted;
            end
        end
        windows_next = update ?
            sbsm_pkg::calc_windows(control_next, prg_sel_next, chr_low_next, chr_high_next) :
            windows_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_shift_reg       <= sbsm_pkg::LOAD_MARKER;
            control_reg          <= '0;
            chr_low_reg          <= '0;
            chr_high_reg         <= '0;
            prg_sel_reg          <= '0;
            windows_reg.prg_win0 <= '0;
            windows_reg.prg_win1 <= sbsm_pkg::PRG_LAST_BANK;
            windows_reg.chr_win0 <= '0;
            windows_reg.chr_win1 <= '0;
        end else begin
            load_shift_reg <= load_shift_next;
            control_reg    <= control_next;
            chr_low_reg    <= chr_low_next;
            chr_high_reg   <= chr_high_next;
            prg_sel_reg    <= prg_sel_next;
            windows_reg    <= windows_next;
        end
    end

    assign windows     = windows_reg;
    assign mirror_next = control_next[1:0];

    // the load register never loses its marker bit
    a_marker_present: assert property (@(posedge aclk) disable iff (!aresetn)
        load_shift_reg != '0)
        else $error("load register lost its marker");

    // a reset write forces program mode 3 on the next cycle
    a_reset_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && wr_reset_bit |=> control_reg[3:2] == 2'b11
            && load_shift_reg == sbsm_pkg::LOAD_MARKER)
        else $error("reset write did not force program mode");

    // a plain shift without completion leaves the windows alone
    a_windows_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !update |=> $stable(windows_reg))
        else $error("windows changed without a register update");

endmodule

// ===== rtl/core/sbsm_decode.sv =====
// Address decode: region, memory offset and store strobe of one access.
module sbsm_decode (
    input  logic                             action,
    input  logic [sbsm_pkg::ADDR_W-1:0]      addr,
    input  sbsm_pkg::windows_t               windows,
    input  logic [sbsm_pkg::LOG2_W-1:0]      prg_log2,
    input  logic [sbsm_pkg::LOG2_W-1:0]      chr_log2,
    output sbsm_pkg::access_t                access
);

    logic [sbsm_pkg::CHR_BANK_W-1:0] chr_bank;
    logic [sbsm_pkg::PRG_BANK_W-1:0] rom_bank;

    always_comb begin
        chr_bank = (addr[12] ? windows.chr_win1 : windows.chr_win0) & sbsm_pkg::chr_mask(chr_log2);
        rom_bank = (addr[14] ? windows.prg_win1 : windows.prg_win0) & sbsm_pkg::prg_mask(prg_log2);
        access.region     = sbsm_pkg::REGION_NONE;
        access.mem_offset = '0;
        access.mem_write  = 1'b0;
        if (addr[15:13] == 3'b000) begin
            access.region     = sbsm_pkg::REGION_CHR;
            access.mem_offset = {chr_bank, addr[11:0]};
            access.mem_write  = action;
        end else if (addr[15]) begin
            if (!action) begin
                // offset keeps its low 17 bits
                access.region     = sbsm_pkg::REGION_PRG;
                access.mem_offset = {rom_bank[2:0], addr[13:0]};
            end
        end else if (addr[14:13] == 2'b11) begin
            access.region     = sbsm_pkg::REGION_WRAM;
            access.mem_offset = {4'b0000, addr[12:0]};
            access.mem_write  = action;
        end
    end

endmodule

// ===== rtl/core/serial_bank_switch_mapper.sv =====
// Top level of the serial bank switch mapper: stream ports, config port, result register.
//
// Usage: each transfer on the s_ channel is one bus access (read or write, address,
// data byte). Every access yields exactly one result transfer on the m_ channel with
// the target region, the byte offset into that memory, a store strobe and the
// current mirroring mode. Writes at 0x8000 and above feed the serial load register
// and return region "none".
// The result is registered: it appears on m_tdata in the cycle after the input transfer.
// Throughput: one access per cycle if m_tready keeps up; the mapper state is updated
// in the same cycle the access is taken, so consecutive accesses see each other's
// register writes. The single result register is the only buffer: s_tready is
// high while it is empty or being drained, so a stalled receiver holds the input
// after one item. Reset (aresetn low, synchronous) empties the result register,
// restores the load marker, clears all bank registers, points program window 1 at
// the last bank and sets the bank counts to 16 program and 32 character banks.
// The APB port sets the bank counts; write it only while the block is idle.
module serial_bank_switch_mapper (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // action, addr[15:0], data[7:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,  // region[1:0], mem_offset[16:0], mem_write, mirror[1:0]
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sbsm_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic                              in_accept;
    logic                              action;
    logic [sbsm_pkg::ADDR_W-1:0]       addr;
    logic [7:0]                        data;
    logic                              m_valid_reg, m_valid_next;
    logic [23:0]                       m_data_reg, m_data_next;
    logic [sbsm_pkg::LOG2_W-1:0]       prg_log2_reg, chr_log2_reg;
    logic                              cfg_write;
    sbsm_pkg::cfg_index_t              cfg_idx;
    sbsm_pkg::windows_t                windows;
    sbsm_pkg::access_t                 access;
    logic [1:0]                        mirror_next;

    assign action    = s_tdata[0];
    assign addr      = s_tdata[16:1];
    assign data      = s_tdata[24:17];
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    sbsm_loader u_loader (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr_en        (in_accept && action && addr[15]),
        .wr_sel       (addr[14:13]),
        .wr_reset_bit (data[7]),
        .wr_data_bit  (data[0]),
        .windows      (windows),
        .mirror_next  (mirror_next)
    );

    sbsm_decode u_decode (
        .action   (action),
        .addr     (addr),
        .windows  (windows),
        .prg_log2 (prg_log2_reg),
        .chr_log2 (chr_log2_reg),
        .access   (access)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (in_accept) begin
            m_valid_next = 1'b1;
            m_data_next  = {2'b00, mirror_next, access.mem_write, access.mem_offset,
                            access.region};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = sbsm_pkg::cfg_index_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_log2_reg <= sbsm_pkg::PRG_LOG2_RST;
            chr_log2_reg <= sbsm_pkg::CHR_LOG2_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                sbsm_pkg::CFG_PRG_LOG2: prg_log2_reg <= pwdata[sbsm_pkg::LOG2_W-1:0];
                sbsm_pkg::CFG_CHR_LOG2: chr_log2_reg <= pwdata[sbsm_pkg::LOG2_W-1:0];
                default:                prg_log2_reg <= prg_log2_reg;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            sbsm_pkg::CFG_PRG_LOG2: prdata = {29'd0, prg_log2_reg};
            sbsm_pkg::CFG_CHR_LOG2: prdata = {29'd0, chr_log2_reg};
            default:                prdata = '0;
        endcase
    end

    // an accepted access always makes the result valid in the next cycle
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> m_valid_reg)
        else $error("accepted access produced no result");

    // program ROM and unmapped accesses never store
    a_store_region: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[19] |->
            (m_data_reg[1:0] == sbsm_pkg::REGION_CHR || m_data_reg[1:0] == sbsm_pkg::REGION_WRAM))
        else $error("store strobe outside writable memory");

    // region none carries a zero offset
    a_none_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[1:0] == sbsm_pkg::REGION_NONE |-> m_data_reg[18:2] == '0)
        else $error("nonzero offset on unmapped access");

endmodule

// ===== verif/tb_serial_bank_switch_mapper.sv =====
// Testbench for serial_bank_switch_mapper: random stream traffic against a window predictor.
module tb_serial_bank_switch_mapper;
    import sbsm_pkg::*;

    localparam logic        ACT_READ   = 1'b0;
    localparam logic        ACT_WRITE  = 1'b1;
    localparam logic [15:0] CHR_END    = 16'h2000;
    localparam logic [15:0] WRAM_BASE  = 16'h6000;
    localparam logic [15:0] REG_BASE   = 16'h8000;
    localparam logic [7:0]  LOAD_RESET = 8'h80;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 80;
    localparam int          PHASE_ITEMS = 38;

    typedef struct {
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  data;
    } bus_access_t;

    typedef struct {
        region_t     region;
        logic [16:0] offset;
        logic        store;
        logic [1:0]  mirror;
    } mapped_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // action, addr[15:0], data[7:0], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // region[1:0], mem_offset[16:0], mem_write, mirror[1:0], zero pad
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    serial_bank_switch_mapper DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // mapper state mirror
    logic [LOG2_W-1:0]     prg_log2;
    logic [LOG2_W-1:0]     chr_log2;
    logic [LOAD_W-1:0]     load_sr;
    logic [LOAD_W-1:0]     ctrl_word;
    logic [CHR_BANK_W-1:0] chr_sel_lo;
    logic [CHR_BANK_W-1:0] chr_sel_hi;
    logic [PRG_BANK_W-1:0] prg_sel;
    logic [PRG_BANK_W-1:0] prg_win [2];
    logic [CHR_BANK_W-1:0] chr_win [2];

    bus_access_t pending_accesses [$];
    mapped_t     pending_maps [$];

    int  errors = 0;
    int  accepted_cnt = 0;
    int  cycle_cnt = 0;
    int  tx_gap = 0;
    int  rx_stall = 0;
    logic tx_burst = 1'b0;
    logic rx_burst = 1'b0;
    logic long_hold = 1'b0;
    logic s_fire = 1'b0;
    logic m_fire = 1'b0;

    function automatic void reset_mapper();
        prg_log2   = PRG_LOG2_RST;
        chr_log2   = CHR_LOG2_RST;
        load_sr    = LOAD_MARKER;
        ctrl_word  = '0;
        chr_sel_lo = '0;
        chr_sel_hi = '0;
        prg_sel    = '0;
        prg_win[0] = '0;
        prg_win[1] = PRG_LAST_BANK;
        chr_win[0] = '0;
        chr_win[1] = '0;
    endfunction

    function automatic void update_windows();
        case (ctrl_word[3:2])
            2'd2: begin
                prg_win[0] = '0;
                prg_win[1] = prg_sel;
            end
            2'd3: begin
                prg_win[0] = prg_sel;
                prg_win[1] = PRG_LAST_BANK;
            end
            default: begin
                prg_win[0] = prg_sel & 4'hE;
                prg_win[1] = prg_sel | 4'h1;
            end
        endcase
        if (ctrl_word[4]) begin
            chr_win[0] = chr_sel_lo;
            chr_win[1] = chr_sel_hi;
        end else begin
            chr_win[0] = chr_sel_lo & 5'h1E;
            chr_win[1] = chr_sel_lo | 5'h01;
        end
    endfunction

    function automatic void shift_in(logic [15:0] a, logic [7:0] d);
        logic done;
        if (d[7]) begin
            load_sr   = LOAD_MARKER;
            ctrl_word = ctrl_word | PRG_MODE_BITS;
            update_windows();
        end else begin
            done    = load_sr[0];
            load_sr = {d[0], load_sr[LOAD_W-1:1]};
            if (done) begin
                case (reg_sel_t'(a[14:13]))
                    SEL_CONTROL:  ctrl_word  = load_sr;
                    SEL_CHR_LOW:  chr_sel_lo = load_sr;
                    SEL_CHR_HIGH: chr_sel_hi = load_sr;
                    default:      prg_sel    = load_sr[PRG_BANK_W-1:0];
                endcase
                load_sr = LOAD_MARKER;
                update_windows();
            end
        end
    endfunction

    function automatic mapped_t map_access(logic wr, logic [15:0] a, logic [7:0] d);
        mapped_t     r;
        int unsigned lim;
        int unsigned bank;
        r.region = REGION_NONE;
        r.offset = '0;
        r.store  = 1'b0;
        if (a < CHR_END) begin
            lim  = (chr_log2 > CHR_LOG2_CAP) ? CHR_LOG2_CAP : chr_log2;
            bank = chr_win[a[12]] & ((1 << lim) - 1);
            r.region = REGION_CHR;
            r.offset = 17'((bank << 12) | a[11:0]);
            r.store  = wr;
        end else if (a >= REG_BASE) begin
            if (wr == ACT_WRITE) begin
                shift_in(a, d);
            end else begin
                lim  = (prg_log2 > PRG_LOG2_CAP) ? PRG_LOG2_CAP : prg_log2;
                bank = prg_win[a[14]] & ((1 << lim) - 1);
                r.region = REGION_PRG;
                r.offset = 17'((bank << 14) | a[13:0]);
            end
        end else if (a >= WRAM_BASE) begin
            r.region = REGION_WRAM;
            r.offset = 17'(a - WRAM_BASE);
            r.store  = wr;
        end
        r.mirror = ctrl_word[1:0];
        return r;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        end
    endfunction

    function automatic int draw_wait(logic burst);
        return burst ? 0 : $urandom_range(0, 4);
    endfunction

    // monitor: results checked, accepted accesses predicted
    always @(posedge aclk) begin
        mapped_t want;
        s_fire <= aresetn && s_tvalid && s_tready;
        m_fire <= aresetn && m_tvalid && m_tready;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_maps.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = pending_maps.pop_front();
                    check_field("region", want.region, m_tdata[1:0]);
                    check_field("mem_offset", want.offset, m_tdata[18:2]);
                    check_field("mem_write", want.store, m_tdata[19]);
                    check_field("mirror", want.mirror, m_tdata[21:20]);
                end
            end
            if (s_tvalid && s_tready) begin
                pending_maps.push_back(map_access(s_tdata[0], s_tdata[16:1], s_tdata[24:17]));
                accepted_cnt++;
            end
        end
    end

    // access driver
    always @(negedge aclk) begin
        bus_access_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
                item = pending_accesses.pop_front();
                s_tdata  <= {7'b0, item.data, item.addr, item.wr};
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    tx_burst = !tx_burst;
                tx_gap = draw_wait(tx_burst);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_fire) begin
                if ($urandom_range(0, 39) == 0)
                    rx_burst = !rx_burst;
                rx_stall = draw_wait(rx_burst);
            end
            if (long_hold) begin
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (accepted_cnt >= 300);
        @(negedge aclk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        long_hold <= 1'b0;
    end

    task automatic push_access(logic wr, logic [15:0] a, logic [7:0] d);
        bus_access_t item;
        item.wr   = wr;
        item.addr = a;
        item.data = d;
        pending_accesses.push_back(item);
    endtask

    task automatic push_reg_load(reg_sel_t sel, logic [4:0] val);
        logic [1:0] tsel;
        for (int i = 0; i < 5; i++) begin
            if (i > 0 && $urandom_range(0, 24) == 0) begin
                push_access(ACT_WRITE, REG_BASE | 16'($urandom), LOAD_RESET | 8'($urandom));
                return;
            end
            tsel = (i == 4) ? sel : 2'($urandom);
            push_access(ACT_WRITE, {1'b1, tsel, 13'($urandom)},
                        {1'b0, 6'($urandom), val[i]});
            if ($urandom_range(0, 3) == 0)
                push_access(ACT_READ, 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic push_random(int count);
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
                push_access(ACT_READ, 16'($urandom), 8'($urandom));
            else if (kind < 55)
                push_access(ACT_WRITE, 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
            else if (kind < 63)
                push_access(ACT_WRITE, REG_BASE | 16'($urandom), 8'($urandom));
            else
                push_reg_load(reg_sel_t'($urandom_range(0, 3)), 5'($urandom));
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_accesses.size() != 0 || s_tvalid || pending_maps.size() != 0);
        repeat (2) @(negedge aclk);
    endtask

    task automatic apb_write(cfg_index_t idx, logic [LOG2_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= ($urandom & ~32'h7) | 32'(v);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == CFG_PRG_LOG2)
            prg_log2 = v;
        else
            chr_log2 = v;
    endtask

    initial begin
        logic [LOG2_W-1:0] prg_set [6];
        logic [LOG2_W-1:0] chr_set [6];
        prg_set = '{3'd0, 3'd7, 3'd1, 3'd4, 3'd5, 3'd2};
        chr_set = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd6, 3'd2};
        reset_mapper();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // region edges, unmapped accesses, load reset, serial loads that a load reset may cut short
        push_access(ACT_READ,  16'h0000, 8'h00);
        push_access(ACT_READ,  16'h1FFF, 8'hFF);
        push_access(ACT_WRITE, 16'h0FFF, 8'hFF);
        push_access(ACT_READ,  16'h2000, 8'h00);
        push_access(ACT_WRITE, 16'h5FFF, 8'hAA);
        push_access(ACT_READ,  16'h6000, 8'h55);
        push_access(ACT_WRITE, 16'h7FFF, 8'h55);
        push_access(ACT_READ,  16'h8000, 8'h00);
        push_access(ACT_READ,  16'hFFFF, 8'h00);
        push_access(ACT_WRITE, 16'h8000, 8'h80);
        push_reg_load(SEL_CONTROL, 5'b11110);
        push_reg_load(SEL_PRG, 5'b11111);
        push_access(ACT_READ,  16'hC000, 8'h00);
        push_access(ACT_READ,  16'hBFFF, 8'h00);
        push_random(PHASE_ITEMS);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            if (p == 5) begin
                apb_write(CFG_PRG_LOG2, 3'($urandom_range(0, 7)));
                apb_write(CFG_CHR_LOG2, 3'($urandom_range(0, 7)));
            end else begin
                apb_write(CFG_PRG_LOG2, prg_set[p]);
                apb_write(CFG_CHR_LOG2, chr_set[p]);
            end
            push_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (4) @(posedge aclk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
